// ===== rtl/fru_pkg.sv =====
package fru_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int DIV_WIDTH   = 32;

   localparam logic [2:0] FUNC_LOAD = 3'd0;
   localparam logic [2:0] FUNC_ADD  = 3'd1;
   localparam logic [2:0] FUNC_SUB  = 3'd2;
   localparam logic [2:0] FUNC_MUL  = 3'd3;
   localparam logic [2:0] FUNC_DIV  = 3'd4;
   localparam logic [2:0] FUNC_NORM = 3'd5;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_ZERO  = 2'd1,
      STAT_NOLCD = 2'd2,
      STAT_OVF   = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] operand_num;
      logic [30:0]        operand_den;
      logic signed [31:0] operand_whole;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [30:0]        res_den;
      logic signed [31:0] res_whole;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_FAIL_ZERO,
      OP_FAIL_NOLCD,
      OP_FAIL_OVF,
      OP_LOAD,
      OP_MUL1,
      OP_MUL2,
      OP_MUL_COMMIT,
      OP_AS_INIT,
      OP_AS_MOD,
      OP_AS_STEP,
      OP_LCD_START,
      OP_LCD_QUO,
      OP_NORM_START,
      OP_NORM_KEEP,
      OP_NORM_SPLIT,
      OP_GCD_STEP,
      OP_GCD_UPDATE,
      OP_RED_NUM,
      OP_RED_NUM_DONE,
      OP_NORM_COMMIT
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CHECK,
      S_MUL1,
      S_MUL2,
      S_MUL3,
      S_AS_MOD,
      S_AS_SEARCH,
      S_AS_QUO,
      S_NORM,
      S_NORM_DIV,
      S_GCD,
      S_GCD_DIV,
      S_RED_NUM,
      S_RED_DEN,
      S_DONE
   } state_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] func;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic den_zero;
      logic opd_zero;
      logic opn_zero;
      logic r_zero;
      logic k_last;
      logic m_ovf;
      logic den_lt_num;
      logic gb_zero;
   } sts_type;

   // true when a wide signed value fits the stored word width
   function automatic logic fits_word(input logic signed [66:0] x);
      logic [66-VALUE_WIDTH+1:0] top;
      top = x[66:VALUE_WIDTH-1];
      return (top == '0) || (top == '1);
   endfunction

endpackage

// ===== rtl/fraction_arithmetic_unit.sv =====
// fraction arithmetic unit: holds one fraction num/den plus a whole part and applies
// one operation per transaction (load, add, subtract, multiply, divide, normalize),
// answering with the stored fraction and a status (ok, zero denominator, no common
// denominator, overflow); on any error the stored fraction is left unchanged. one
// transaction is in work at a time. add and subtract search for k (at most
// MAX_MULTIPLES), the multiple of the larger denominator that gives the common
// denominator: the search tests one multiple a cycle and two passes of the shared
// radix-2 divider frame it. normalize uses one divider pass for the whole-part split,
// one per euclid step of the gcd and two for the reduction. a finished result sits
// in an output register, so a new transaction is accepted while the previous one
// waits to be taken.
module fraction_arithmetic_unit import fru_pkg::*; #(
   parameter int MAX_MULTIPLES = 100
) (
   input  logic    clock,
   input  logic    reset,
   // request channel
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   // response channel
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: decodes the function code and steps through the operation
   fru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   // datapath: fraction registers, shared multiplier, iterative divider,
   // common denominator search and response register
   fru_dp #(
      .MAX_MULTIPLES (MAX_MULTIPLES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

// ===== rtl/fru_div.sv =====
module fru_div import fru_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_WIDTH-1:0] dividend,
   input  logic [DIV_WIDTH-1:0] divisor,
   output logic [DIV_WIDTH-1:0] quotient,
   output logic [DIV_WIDTH-1:0] remainder,
   output logic                 done
);

   localparam int CW = $clog2(DIV_WIDTH + 1);

   logic [DIV_WIDTH-1:0] quo_ff, rem_ff, dsr_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 done_ff;
   logic [DIV_WIDTH:0]   shifted, diff;
   logic                 ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_WIDTH-1]};
      diff    = shifted - {1'b0, dsr_ff};
      ge      = !diff[DIV_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == CW'(1));
         if (start) begin
            cnt_ff <= CW'(DIV_WIDTH);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
      end
   end

   // restoring division, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (cnt_ff != '0) begin
         quo_ff <= {quo_ff[DIV_WIDTH-2:0], ge};
         rem_ff <= ge ? diff[DIV_WIDTH-1:0] : shifted[DIV_WIDTH-1:0];
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

// ===== rtl/fru_dp.sv =====
module fru_dp import fru_pkg::*; #(
   parameter int MAX_MULTIPLES = 100
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_data
);

   localparam int KW = $clog2(MAX_MULTIPLES + 1);

   logic signed [31:0] num_ff, whole_ff;
   logic [30:0]        den_ff;
   logic signed [31:0] opn_ff, opw_ff;
   logic [30:0]        opd_ff;
   status_type         stat_ff;
   logic signed [65:0] prod_ff, t1_ff;
   logic [30:0]        big_ff, small_ff, m_ff, c_ff, r_ff, q_ff;
   logic               den_big_ff;
   logic [KW-1:0]      k_ff;
   logic signed [31:0] n_ff, w_ff;
   logic [31:0]        ga_ff, gb_ff;
   rsp_type            rsp_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_prod;
   logic [30:0]        k_word, f_den, f_op, big_sel, small_sel;
   logic signed [32:0] od_signed;
   logic signed [65:0] abs_prod;
   logic signed [66:0] sum;
   logic               commit_ok;
   logic [31:0]        m_next, r_sum, r_next;
   logic [31:0]        n_mag, num_mag;
   logic               div_start, div_done;
   logic [31:0]        div_a, div_b, div_q, div_r;

   always_comb begin
      k_word    = {{(31-KW){1'b0}}, k_ff};
      f_den     = den_big_ff ? k_word : q_ff;
      f_op      = den_big_ff ? q_ff : k_word;
      big_sel   = (den_ff > opd_ff) ? den_ff : opd_ff;
      small_sel = (den_ff > opd_ff) ? opd_ff : den_ff;
      od_signed = {2'b00, opd_ff};
      n_mag     = n_ff[31] ? 32'(-n_ff) : 32'(n_ff);
      num_mag   = num_ff[31] ? 32'(-num_ff) : 32'(num_ff);
      m_next    = {1'b0, m_ff} + {1'b0, big_ff};
      r_sum     = {1'b0, r_ff} + {1'b0, c_ff};
      r_next    = (r_sum >= {1'b0, small_ff}) ? r_sum - {1'b0, small_ff} : r_sum;
   end

   // operand selection for the shared multiplier
   always_comb begin
      mul_a = {num_ff[31], num_ff};
      mul_b = {opn_ff[31], opn_ff};
      if (cmd.op == OP_MUL1) begin
         mul_a = {num_ff[31], num_ff};
         case (cmd.func)
            FUNC_MUL: mul_b = {opn_ff[31], opn_ff};
            FUNC_DIV: mul_b = opn_ff[31] ? -od_signed : od_signed;
            default:  mul_b = {2'b00, f_den};
         endcase
      end else begin
         case (cmd.func)
            FUNC_MUL: begin
               mul_a = {2'b00, den_ff};
               mul_b = od_signed;
            end
            FUNC_DIV: begin
               mul_a = {2'b00, den_ff};
               mul_b = {opn_ff[31], opn_ff};
            end
            default: begin
               mul_a = {opn_ff[31], opn_ff};
               mul_b = {2'b00, f_op};
            end
         endcase
      end
      mul_prod = mul_a * mul_b;
   end

   always_comb begin
      abs_prod = prod_ff[65] ? -prod_ff : prod_ff;
      if (cmd.func == FUNC_SUB) begin
         sum = {t1_ff[65], t1_ff} - {prod_ff[65], prod_ff};
      end else begin
         sum = {t1_ff[65], t1_ff} + {prod_ff[65], prod_ff};
      end
      case (cmd.func)
         FUNC_MUL: commit_ok = fits_word({t1_ff[65], t1_ff}) && fits_word({prod_ff[65], prod_ff});
         FUNC_DIV: commit_ok = fits_word({t1_ff[65], t1_ff}) &&
                               fits_word({abs_prod[65], abs_prod});
         default:  commit_ok = fits_word({t1_ff[65], t1_ff}) &&
                               fits_word({prod_ff[65], prod_ff}) && fits_word(sum);
      endcase
   end

   // divider operand selection
   always_comb begin
      div_start = 1'b1;
      div_a     = {1'b0, big_sel};
      div_b     = {1'b0, small_sel};
      case (cmd.op)
         OP_AS_INIT: begin
            div_a = {1'b0, big_sel};
            div_b = {1'b0, small_sel};
         end
         OP_LCD_START: begin
            div_a = {1'b0, m_ff};
            div_b = {1'b0, small_ff};
         end
         OP_NORM_START: begin
            div_a = 32'(num_ff);
            div_b = {1'b0, den_ff};
         end
         OP_GCD_STEP: begin
            div_a = ga_ff;
            div_b = gb_ff;
         end
         OP_RED_NUM: begin
            div_a = n_mag;
            div_b = ga_ff;
         end
         OP_RED_NUM_DONE: begin
            div_a = {1'b0, den_ff};
            div_b = ga_ff;
         end
         default: div_start = 1'b0;
      endcase
   end

   fru_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .quotient  (div_q),
      .remainder (div_r),
      .done      (div_done)
   );

   // stored fraction
   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff   <= '0;
         den_ff   <= '0;
         whole_ff <= '0;
      end else begin
         case (cmd.op)
            OP_LOAD: begin
               num_ff   <= opn_ff;
               den_ff   <= opd_ff;
               whole_ff <= opw_ff;
            end
            OP_MUL_COMMIT: begin
               if (commit_ok) begin
                  case (cmd.func)
                     FUNC_MUL: begin
                        num_ff <= t1_ff[31:0];
                        den_ff <= prod_ff[30:0];
                     end
                     FUNC_DIV: begin
                        num_ff <= t1_ff[31:0];
                        den_ff <= abs_prod[30:0];
                     end
                     default: begin
                        num_ff <= sum[31:0];
                        den_ff <= m_ff;
                     end
                  endcase
               end
            end
            OP_NORM_COMMIT: begin
               num_ff   <= n_ff;
               den_ff   <= div_q[30:0];
               whole_ff <= w_ff;
            end
            default: ;
         endcase
      end
   end

   // operands, scratch and status
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CAPTURE: begin
            opn_ff  <= req_data.operand_num;
            opd_ff  <= req_data.operand_den;
            opw_ff  <= req_data.operand_whole;
            stat_ff <= STAT_OK;
         end
         OP_FAIL_ZERO:  stat_ff <= STAT_ZERO;
         OP_FAIL_NOLCD: stat_ff <= STAT_NOLCD;
         OP_FAIL_OVF:   stat_ff <= STAT_OVF;
         OP_MUL1:       prod_ff <= mul_prod;
         OP_MUL2: begin
            t1_ff   <= prod_ff;
            prod_ff <= mul_prod;
         end
         OP_MUL_COMMIT: begin
            if (!commit_ok) begin
               stat_ff <= STAT_OVF;
            end
         end
         OP_AS_INIT: begin
            big_ff     <= big_sel;
            small_ff   <= small_sel;
            m_ff       <= big_sel;
            den_big_ff <= den_ff > opd_ff;
            k_ff       <= KW'(1);
         end
         OP_AS_MOD: begin
            c_ff <= div_r[30:0];
            r_ff <= div_r[30:0];
         end
         OP_AS_STEP: begin
            m_ff <= m_next[30:0];
            r_ff <= r_next[30:0];
            k_ff <= k_ff + KW'(1);
         end
         OP_LCD_QUO: q_ff <= div_q[30:0];
         OP_NORM_KEEP: begin
            n_ff  <= num_ff;
            w_ff  <= whole_ff;
            ga_ff <= num_mag;
            gb_ff <= {1'b0, den_ff};
         end
         OP_NORM_SPLIT: begin
            n_ff  <= div_r;
            w_ff  <= div_q;
            ga_ff <= div_r;
            gb_ff <= {1'b0, den_ff};
         end
         OP_GCD_UPDATE: begin
            ga_ff <= gb_ff;
            gb_ff <= div_r;
         end
         OP_RED_NUM_DONE: n_ff <= n_ff[31] ? -div_q : div_q;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.res_num   <= num_ff;
         rsp_ff.res_den   <= den_ff;
         rsp_ff.res_whole <= whole_ff;
         rsp_ff.status    <= stat_ff;
      end
   end

   always_comb begin
      sts.div_done   = div_done;
      sts.den_zero   = (den_ff == '0);
      sts.opd_zero   = (opd_ff == '0);
      sts.opn_zero   = (opn_ff == '0);
      sts.r_zero     = (r_ff == '0);
      sts.k_last     = (k_ff == KW'(MAX_MULTIPLES));
      sts.m_ovf      = m_next[31];
      sts.den_lt_num = !num_ff[31] && ({1'b0, den_ff} < 32'(num_ff));
      sts.gb_zero    = (gb_ff == '0);
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/fru_ctrl.sv =====
module fru_ctrl import fru_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [2:0] req_func,
   input  logic       rsp_stall,
   input  sts_type    sts,
   output cmd_type    cmd,
   output logic       req_stall,
   output logic       rsp_valid
);

   state_type  state_ff, state_in;
   logic [2:0] func_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       zero_fail, slot_free;

   always_comb begin
      zero_fail = ((func_ff inside {FUNC_LOAD, FUNC_ADD, FUNC_SUB, FUNC_MUL}) && sts.opd_zero) ||
                  (func_ff == FUNC_DIV && sts.opn_zero) ||
                  ((func_ff inside {FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV, FUNC_NORM}) &&
                   sts.den_zero);
      slot_free = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_CHECK;
         S_CHECK: begin
            if (zero_fail) begin
               state_in = S_DONE;
            end else begin
               case (func_ff)
                  FUNC_ADD, FUNC_SUB: state_in = S_AS_MOD;
                  FUNC_MUL, FUNC_DIV: state_in = S_MUL2;
                  FUNC_NORM:          state_in = S_NORM;
                  default:            state_in = S_DONE;
               endcase
            end
         end
         S_MUL1:     state_in = S_MUL2;
         S_MUL2:     state_in = S_MUL3;
         S_MUL3:     state_in = S_DONE;
         S_AS_MOD:   if (sts.div_done) state_in = S_AS_SEARCH;
         S_AS_SEARCH: begin
            if (sts.r_zero) begin
               state_in = S_AS_QUO;
            end else if (sts.k_last || sts.m_ovf) begin
               state_in = S_DONE;
            end
         end
         S_AS_QUO:   if (sts.div_done) state_in = S_MUL1;
         S_NORM:     state_in = sts.den_lt_num ? S_NORM_DIV : S_GCD;
         S_NORM_DIV: if (sts.div_done) state_in = S_GCD;
         S_GCD:      state_in = sts.gb_zero ? S_RED_NUM : S_GCD_DIV;
         S_GCD_DIV:  if (sts.div_done) state_in = S_GCD;
         S_RED_NUM:  if (sts.div_done) state_in = S_RED_DEN;
         S_RED_DEN:  if (sts.div_done) state_in = S_DONE;
         S_DONE:     if (slot_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op       = OP_NONE;
      cmd.func     = func_ff;
      cmd.rsp_load = 1'b0;
      unique case (state_ff)
         S_IDLE:  if (req_valid) cmd.op = OP_CAPTURE;
         S_CHECK: begin
            if (zero_fail) begin
               cmd.op = OP_FAIL_ZERO;
            end else begin
               case (func_ff)
                  FUNC_LOAD:          cmd.op = OP_LOAD;
                  FUNC_ADD, FUNC_SUB: cmd.op = OP_AS_INIT;
                  FUNC_MUL, FUNC_DIV: cmd.op = OP_MUL1;
                  default:            cmd.op = OP_NONE;
               endcase
            end
         end
         S_MUL1:   cmd.op = OP_MUL1;
         S_MUL2:   cmd.op = OP_MUL2;
         S_MUL3:   cmd.op = OP_MUL_COMMIT;
         S_AS_MOD: if (sts.div_done) cmd.op = OP_AS_MOD;
         S_AS_SEARCH: begin
            if (sts.r_zero) begin
               cmd.op = OP_LCD_START;
            end else if (sts.k_last) begin
               cmd.op = OP_FAIL_NOLCD;
            end else if (sts.m_ovf) begin
               cmd.op = OP_FAIL_OVF;
            end else begin
               cmd.op = OP_AS_STEP;
            end
         end
         S_AS_QUO:   if (sts.div_done) cmd.op = OP_LCD_QUO;
         S_NORM:     cmd.op = sts.den_lt_num ? OP_NORM_START : OP_NORM_KEEP;
         S_NORM_DIV: if (sts.div_done) cmd.op = OP_NORM_SPLIT;
         S_GCD:      cmd.op = sts.gb_zero ? OP_RED_NUM : OP_GCD_STEP;
         S_GCD_DIV:  if (sts.div_done) cmd.op = OP_GCD_UPDATE;
         S_RED_NUM:  if (sts.div_done) cmd.op = OP_RED_NUM_DONE;
         S_RED_DEN:  if (sts.div_done) cmd.op = OP_NORM_COMMIT;
         S_DONE:     cmd.rsp_load = slot_free;
         default:    cmd.op = OP_NONE;
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         func_ff <= req_func;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/fru_checker.sv =====
module fru_checker import fru_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // an accepted transaction keeps the unit busy the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("unit not busy after accepting a transaction");

   // a new response appears together with the unit going idle
   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("response raised while unit still busy");

   // reset leaves the unit idle with no response pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("unit not idle after reset");

endmodule

bind fraction_arithmetic_unit fru_checker u_checker (.*);

// ===== dv/tb_fraction_arithmetic_unit.sv =====
`timescale 1ns / 100ps

module tb_fraction_arithmetic_unit;
   import fru_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   fraction_arithmetic_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // predicted copy of the stored fraction, 64-bit signed for range checks
   longint frac_num_q;
   longint frac_den_q;
   longint whole_q;

   rsp_type expected_rsps[$];
   int      mismatch_count;
   int      idle_cycles;

   // idling controls: percent of cycles the sender idles / receiver stalls
   int      send_idle_pct;
   int      recv_stall_pct;
   bit      hold_off;

   localparam longint HI_LIM = 64'sd2147483647;
   localparam longint LO_LIM = -64'sd2147483648;
   localparam int     WATCHDOG_LIMIT = 20000;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic bit fits(input longint v);
      return (v >= LO_LIM) && (v <= HI_LIM);
   endfunction

   function automatic longint gcd_of(input longint a, input longint b);
      longint t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // add or subtract the operand using the least common denominator
   function automatic status_type lcd_add_sub(input longint n2, input longint d2,
                                              input bit subtract);
      longint big, sml, m, lcd, t1, t2, s;
      big = (frac_den_q > d2) ? frac_den_q : d2;
      sml = (frac_den_q > d2) ? d2 : frac_den_q;
      m = big;
      lcd = 0;
      for (int k = 1; k <= 100; k++) begin
         if (k > 1) begin
            m = m + big;
            if (!fits(m)) return STAT_OVF;
         end
         if (m % sml == 0) begin
            lcd = m;
            break;
         end
      end
      if (lcd == 0) return STAT_NOLCD;
      t1 = frac_num_q * (lcd / frac_den_q);
      if (!fits(t1)) return STAT_OVF;
      t2 = n2 * (lcd / d2);
      if (!fits(t2)) return STAT_OVF;
      s = subtract ? t1 - t2 : t1 + t2;
      if (!fits(s)) return STAT_OVF;
      frac_num_q = s;
      frac_den_q = lcd;
      return STAT_OK;
   endfunction

   // apply one transaction to the predicted fraction, return the response
   function automatic rsp_type fraction_step(input req_type rq);
      longint     on, od, ow, a, b, n, d, w, g;
      status_type st;
      rsp_type    r;
      on = longint'(rq.operand_num);
      od = longint'({1'b0, rq.operand_den});
      ow = longint'(rq.operand_whole);
      st = STAT_OK;
      if (rq.func <= FUNC_MUL && od == 0) st = STAT_ZERO;
      else if (rq.func == FUNC_DIV && on == 0) st = STAT_ZERO;
      else if (rq.func >= FUNC_ADD && rq.func <= FUNC_NORM && frac_den_q == 0)
         st = STAT_ZERO;
      else begin
         case (rq.func)
            FUNC_LOAD: begin
               frac_num_q = on;
               frac_den_q = od;
               whole_q = ow;
            end
            FUNC_ADD: st = lcd_add_sub(on, od, 1'b0);
            FUNC_SUB: st = lcd_add_sub(on, od, 1'b1);
            FUNC_MUL: begin
               a = frac_num_q * on;
               b = frac_den_q * od;
               if (!fits(a) || !fits(b)) st = STAT_OVF;
               else begin
                  frac_num_q = a;
                  frac_den_q = b;
               end
            end
            FUNC_DIV: begin
               // sign of the operand moves into the numerator
               a = frac_num_q * ((on < 0) ? -od : od);
               b = frac_den_q * on;
               if (b < 0) b = -b;
               if (!fits(a) || !fits(b)) st = STAT_OVF;
               else begin
                  frac_num_q = a;
                  frac_den_q = b;
               end
            end
            FUNC_NORM: begin
               n = frac_num_q;
               d = frac_den_q;
               w = whole_q;
               if (d < n) begin
                  w = n / d;
                  n = n % d;
               end
               g = gcd_of((n < 0) ? -n : n, d);
               frac_num_q = n / g;
               frac_den_q = d / g;
               whole_q = w;
            end
            default: ;
         endcase
      end
      r.res_num = frac_num_q[31:0];
      r.res_den = frac_den_q[30:0];
      r.res_whole = whole_q[31:0];
      r.status = st;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // directed table; want_check marks rows with a hand-typed response
   // ---------------------------------------------------------------
   typedef struct {
      req_type rq;
      bit      want_check;
      rsp_type want;
   } directed_row_type;

   directed_row_type directed_rows[$];

   function automatic req_type mk_req(input logic [2:0] f, input longint n,
                                      input longint d, input longint w);
      req_type r;
      r.func = f;
      r.operand_num = n[31:0];
      r.operand_den = d[30:0];
      r.operand_whole = w[31:0];
      return r;
   endfunction

   function automatic rsp_type mk_rsp(input longint n, input longint d,
                                      input longint w, input status_type s);
      rsp_type r;
      r.res_num = n[31:0];
      r.res_den = d[30:0];
      r.res_whole = w[31:0];
      r.status = s;
      return r;
   endfunction

   task automatic add_row(input req_type rq, input bit chk, input rsp_type want);
      directed_row_type row;
      row.rq = rq;
      row.want_check = chk;
      row.want = want;
      directed_rows.push_back(row);
   endtask

   task automatic build_directed();
      rsp_type none;
      none = '0;
      // after reset the denominator is zero: every arithmetic op reports it
      add_row(mk_req(FUNC_ADD, 1, 1, 0), 1, mk_rsp(0, 0, 0, STAT_ZERO));
      add_row(mk_req(FUNC_NORM, 0, 0, 0), 1, mk_rsp(0, 0, 0, STAT_ZERO));
      add_row(mk_req(FUNC_DIV, 3, 4, 0), 1, mk_rsp(0, 0, 0, STAT_ZERO));
      // loading a zero denominator is refused
      add_row(mk_req(FUNC_LOAD, 5, 0, 9), 1, mk_rsp(0, 0, 0, STAT_ZERO));
      // extremes loaded
      add_row(mk_req(FUNC_LOAD, LO_LIM, HI_LIM, HI_LIM), 1,
              mk_rsp(LO_LIM, HI_LIM, HI_LIM, STAT_OK));
      add_row(mk_req(FUNC_MUL, 2, 1, 0), 1,
              mk_rsp(LO_LIM, HI_LIM, HI_LIM, STAT_OVF));
      add_row(mk_req(FUNC_LOAD, HI_LIM, 1, LO_LIM), 1,
              mk_rsp(HI_LIM, 1, LO_LIM, STAT_OK));
      add_row(mk_req(FUNC_ADD, 1, 1, 0), 1, mk_rsp(HI_LIM, 1, LO_LIM, STAT_OVF));
      add_row(mk_req(FUNC_DIV, 0, 1, 0), 1, mk_rsp(HI_LIM, 1, LO_LIM, STAT_ZERO));
      // unused codes change nothing
      add_row(mk_req(3'd6, -1, HI_LIM, -1), 1, mk_rsp(HI_LIM, 1, LO_LIM, STAT_OK));
      add_row(mk_req(3'd7, -1, HI_LIM, -1), 1, mk_rsp(HI_LIM, 1, LO_LIM, STAT_OK));
      // ordinary arithmetic, equal denominators, lcd search
      add_row(mk_req(FUNC_LOAD, 3, 4, 0), 0, none);
      add_row(mk_req(FUNC_ADD, 1, 4, 0), 0, none);
      add_row(mk_req(FUNC_SUB, 5, 6, 0), 0, none);
      add_row(mk_req(FUNC_MUL, -7, 3, 0), 0, none);
      add_row(mk_req(FUNC_DIV, -5, 2, 0), 0, none);
      add_row(mk_req(FUNC_NORM, 0, 0, 0), 0, none);
      // split of whole part, whole part replaced
      add_row(mk_req(FUNC_LOAD, 22, 6, 100), 0, none);
      add_row(mk_req(FUNC_NORM, 0, 0, 0), 0, none);
      // zero numerator reduces to 0/1
      add_row(mk_req(FUNC_LOAD, 0, 7, 0), 0, none);
      add_row(mk_req(FUNC_NORM, 0, 0, 0), 0, none);
      // coprime large denominators exhaust the search
      add_row(mk_req(FUNC_LOAD, 1, 1009, 0), 0, none);
      add_row(mk_req(FUNC_ADD, 1, 1013, 0), 1, mk_rsp(1, 1009, 0, STAT_NOLCD));
      // multiple leaves range during search
      add_row(mk_req(FUNC_LOAD, 1, HI_LIM, 0), 0, none);
      add_row(mk_req(FUNC_SUB, 1, 3, 0), 0, none);
   endtask

   // ---------------------------------------------------------------
   // sender: valid stays up between back-to-back transactions
   // ---------------------------------------------------------------
   task automatic send_req(input req_type rq);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsps.push_back(fraction_step(rq));
   endtask

   function automatic longint rand_small_den();
      case ($urandom_range(3))
         0: return longint'($urandom_range(1, 12));
         1: return longint'($urandom_range(1, 300));
         2: return longint'($urandom_range(1, 60000));
         default: return longint'({1'b0, 31'($urandom)});
      endcase
   endfunction

   function automatic longint rand_num();
      int unsigned u;
      u = $urandom;
      case ($urandom_range(3))
         0: return longint'($signed(32'($urandom_range(0, 40)) - 32'd20));
         1: return longint'($signed(32'($urandom_range(0, 2000)) - 32'd1000));
         2: return longint'($signed(u % 2000000) - 1000000);
         default: return longint'($signed(u));
      endcase
   endfunction

   function automatic req_type rand_req();
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 15) r.func = FUNC_LOAD;
      else if (pick < 32) r.func = FUNC_ADD;
      else if (pick < 49) r.func = FUNC_SUB;
      else if (pick < 63) r.func = FUNC_MUL;
      else if (pick < 77) r.func = FUNC_DIV;
      else if (pick < 96) r.func = FUNC_NORM;
      else r.func = 3'($urandom_range(6, 7));
      r.operand_num = 32'(rand_num());
      r.operand_den = ($urandom_range(49) == 0) ? 31'd0 : 31'(rand_small_den());
      r.operand_whole = $urandom;
      return r;
   endfunction

   // phase settings: sender idle, receiver stall
   task automatic set_phase(input int ph);
      case (ph)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
         default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
   endtask

   // ---------------------------------------------------------------
   // receiver: stall driven at the clock edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
      end
   end

   // compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: %h", rsp_data);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.res_num !== want.res_num || rsp_data.res_den !== want.res_den ||
                rsp_data.res_whole !== want.res_whole ||
                rsp_data.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp num %0d den %0d whole %0d st %0d, got num %0d den %0d whole %0d st %0d",
                           want.res_num, want.res_den, want.res_whole, want.status,
                           rsp_data.res_num, rsp_data.res_den, rsp_data.res_whole,
                           rsp_data.status);
            end
         end
      end
   end

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL fraction_arithmetic_unit");
         $finish;
      end
   end

   // long receiver hold-off in its own process so the block backs up
   task automatic long_hold_off();
      hold_off = 1'b1;
      repeat (3000) @(posedge clock);
      hold_off = 1'b0;
   endtask

   initial begin
      req_type rq;
      rsp_type hand_want;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      hold_off = 1'b0;
      mismatch_count = 0;
      idle_cycles = 0;
      set_phase(0);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, rows with a typed-in response are cross-checked
      build_directed();
      foreach (directed_rows[i]) begin
         send_req(directed_rows[i].rq);
         if (directed_rows[i].want_check) begin
            hand_want = expected_rsps[expected_rsps.size() - 1];
            if (hand_want !== directed_rows[i].want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("table row %0d: exp %h, predicted %h", i,
                           directed_rows[i].want, hand_want);
            end
         end
      end

      // random part over the idling phases, with one long hold-off
      for (int ph = 0; ph < 4; ph++) begin
         set_phase(ph);
         if (ph == 2) begin
            fork
               long_hold_off();
            join_none
         end
         for (int n = 0; n < 110; n++) begin
            if ($urandom_range(5) == 0)
               rq = mk_req(FUNC_LOAD, rand_num(), rand_small_den(), longint'($urandom));
            else
               rq = rand_req();
            send_req(rq);
         end
      end
      req_valid <= 1'b0;

      set_phase(0);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS fraction_arithmetic_unit");
      else
         $display("FAIL fraction_arithmetic_unit");
      $finish;
   end

endmodule
